FILE: hdl/dlt_pkg.sv
package dlt_pkg;

  localparam int DATA_W             = 32;
  localparam int REQ_W              = 2;
  localparam int STATUS_W           = 2;
  localparam int DEFAULT_MAX_TIMERS = 16;

  // request codes
  localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TICK   = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EXPIRED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic load;
    logic walk;
    logic tail;
    logic resp_load;
  } dlt_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic is_add;
    logic walk_done;
  } dlt_sts_t;

endpackage

FILE: hdl/dlt_if.sv
interface dlt_in_if;
  import dlt_pkg::*;

  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic [DATA_W-1:0]   pkt_num;
  logic [DATA_W-1:0]   duration;

  modport source (output valid, output req_type, output pkt_num, output duration,
                  input ready);
  modport sink   (input valid, input req_type, input pkt_num, input duration,
                  output ready);
endinterface

interface dlt_out_if;
  import dlt_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [DATA_W-1:0]   expired_packet;

  modport source (output valid, output status, output expired_packet, input ready);
  modport sink   (input valid, input status, input expired_packet, output ready);
endinterface

FILE: hdl/dlt_ram.sv
module dlt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/dlt_datapath.sv
module dlt_datapath #(
  parameter int MAX_TIMERS = dlt_pkg::DEFAULT_MAX_TIMERS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  dlt_pkg::dlt_cmd_t              cmd_i,
  output dlt_pkg::dlt_sts_t              sts_o,
  input  logic [dlt_pkg::REQ_W-1:0]      in_req_type,
  input  logic [dlt_pkg::DATA_W-1:0]     in_pkt_num,
  input  logic [dlt_pkg::DATA_W-1:0]     in_duration,
  output logic [dlt_pkg::STATUS_W-1:0]   out_status,
  output logic [dlt_pkg::DATA_W-1:0]     out_expired_packet
);
  import dlt_pkg::*;

  localparam int CW = $clog2(MAX_TIMERS + 1);
  localparam int IW = $clog2(MAX_TIMERS);
  localparam int EW = 2 * DATA_W;

  logic [REQ_W-1:0]    req_r, req_nxt;
  logic [DATA_W-1:0]   pkt_r, pkt_nxt;
  logic [DATA_W-1:0]   dur_rem_r, dur_rem_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       rd_cnt_r, rd_cnt_nxt;
  logic                dvalid_r, dvalid_nxt;
  logic [IW-1:0]       d_idx_r, d_idx_nxt;
  logic                found_r, found_nxt;
  logic [DATA_W-1:0]   carry_delta_r, carry_delta_nxt;
  logic [DATA_W-1:0]   carry_pkt_r, carry_pkt_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [DATA_W-1:0]   expired_r, expired_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [DATA_W-1:0]   out_expired_r, out_expired_nxt;

  logic [EW-1:0]       rd_data;
  logic [DATA_W-1:0]   d_delta;
  logic [DATA_W-1:0]   d_pkt;
  logic [DATA_W-1:0]   dec;
  logic                wr_en;
  logic [IW-1:0]       wr_addr;
  logic [EW-1:0]       wr_data;
  logic [IW-1:0]       rd_addr;
  logic [CW-1:0]       cnt_m1;
  logic [IW-1:0]       last_idx;
  logic                issue;
  logic                full;

  assign d_delta  = rd_data[EW-1:DATA_W];
  assign d_pkt    = rd_data[DATA_W-1:0];
  assign dec      = d_delta - 1'b1;
  assign cnt_m1   = count_r - 1'b1;
  assign last_idx = cnt_m1[IW-1:0];
  assign issue    = rd_cnt_r < count_r;
  assign full     = count_r == CW'(MAX_TIMERS);
  // entry 0 is fetched during the accept cycle
  assign rd_addr  = cmd_i.walk ? rd_cnt_r[IW-1:0] : '0;

  assign sts_o.empty     = count_r == '0;
  assign sts_o.full      = full;
  assign sts_o.is_add    = req_r == REQ_ADD;
  assign sts_o.walk_done = dvalid_r && (d_idx_r == last_idx);

  dlt_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_TIMERS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    req_nxt         = req_r;
    pkt_nxt         = pkt_r;
    dur_rem_nxt     = dur_rem_r;
    count_nxt       = count_r;
    rd_cnt_nxt      = rd_cnt_r;
    dvalid_nxt      = dvalid_r;
    d_idx_nxt       = d_idx_r;
    found_nxt       = found_r;
    carry_delta_nxt = carry_delta_r;
    carry_pkt_nxt   = carry_pkt_r;
    status_nxt      = status_r;
    expired_nxt     = expired_r;
    out_status_nxt  = out_status_r;
    out_expired_nxt = out_expired_r;
    wr_en           = 1'b0;
    wr_addr         = '0;
    wr_data         = {dur_rem_r, pkt_r};

    if (cmd_i.load) begin
      req_nxt         = in_req_type;
      pkt_nxt         = in_pkt_num;
      dur_rem_nxt     = in_duration;
      rd_cnt_nxt      = CW'(1);
      dvalid_nxt      = 1'b1;
      d_idx_nxt       = '0;
      found_nxt       = 1'b0;
      carry_delta_nxt = '0;
      carry_pkt_nxt   = '0;
      expired_nxt     = '0;
      if (in_req_type == REQ_ADD && full) begin
        status_nxt = ST_FULL;
      end else if (in_req_type == REQ_REMOVE) begin
        status_nxt = ST_NOTFOUND;
      end else begin
        status_nxt = ST_DONE;
      end
    end

    if (cmd_i.walk) begin
      dvalid_nxt = issue;
      d_idx_nxt  = rd_cnt_r[IW-1:0];
      if (issue) begin
        rd_cnt_nxt = rd_cnt_r + 1'b1;
      end
      if (dvalid_r) begin
        case (req_r)
          REQ_ADD: begin
            if (found_r) begin
              // ripple the displaced entry one slot up
              wr_en         = 1'b1;
              wr_addr       = d_idx_r;
              wr_data       = {carry_delta_r, carry_pkt_r};
              carry_delta_nxt = d_delta;
              carry_pkt_nxt   = d_pkt;
            end else if (d_delta <= dur_rem_r) begin
              dur_rem_nxt = dur_rem_r - d_delta;
            end else begin
              wr_en           = 1'b1;
              wr_addr         = d_idx_r;
              wr_data         = {dur_rem_r, pkt_r};
              carry_delta_nxt = d_delta - dur_rem_r;
              carry_pkt_nxt   = d_pkt;
              found_nxt       = 1'b1;
            end
          end
          REQ_REMOVE: begin
            if (found_r) begin
              // close the gap; the removed delta folds into the first follower
              wr_en           = 1'b1;
              wr_addr         = d_idx_r - 1'b1;
              wr_data         = {d_delta + carry_delta_r, d_pkt};
              carry_delta_nxt = '0;
            end else if (d_pkt == pkt_r) begin
              found_nxt       = 1'b1;
              carry_delta_nxt = d_delta;
              status_nxt      = ST_DONE;
            end
          end
          REQ_TICK: begin
            if (found_r) begin
              wr_en   = 1'b1;
              wr_addr = d_idx_r - 1'b1;
              wr_data = {d_delta, d_pkt};
            end else if (d_idx_r == '0) begin
              if (d_delta != '0 && dec != '0) begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = {dec, d_pkt};
              end else begin
                found_nxt   = 1'b1;
                status_nxt  = ST_EXPIRED;
                expired_nxt = d_pkt;
              end
            end
          end
          default: begin
          end
        endcase
      end
      if (sts_o.walk_done && req_r != REQ_ADD && found_nxt) begin
        count_nxt = count_r - 1'b1;
      end
    end

    if (cmd_i.tail) begin
      wr_en     = 1'b1;
      wr_addr   = count_r[IW-1:0];
      wr_data   = found_r ? {carry_delta_r, carry_pkt_r} : {dur_rem_r, pkt_r};
      count_nxt = count_r + 1'b1;
    end

    if (cmd_i.resp_load) begin
      out_status_nxt  = status_r;
      out_expired_nxt = expired_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      dvalid_r <= 1'b0;
      found_r  <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      dvalid_r <= dvalid_nxt;
      found_r  <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r         <= req_nxt;
    pkt_r         <= pkt_nxt;
    dur_rem_r     <= dur_rem_nxt;
    rd_cnt_r      <= rd_cnt_nxt;
    d_idx_r       <= d_idx_nxt;
    carry_delta_r <= carry_delta_nxt;
    carry_pkt_r   <= carry_pkt_nxt;
    status_r      <= status_nxt;
    expired_r     <= expired_nxt;
    out_status_r  <= out_status_nxt;
    out_expired_r <= out_expired_nxt;
  end

  assign out_status         = out_status_r;
  assign out_expired_packet = out_expired_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_TIMERS))
    else $error("entry count above capacity");

  a_tail_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.tail |-> !full)
    else $error("append into a full store");

  a_walk_wr_live: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_i.walk && wr_en) |-> (CW'(wr_addr) < count_r))
    else $error("walk write beyond live entries");

  a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.walk |-> count_r != '0)
    else $error("walk over an empty list");
`endif

endmodule

FILE: hdl/dlt_ctrl.sv
module dlt_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [dlt_pkg::REQ_W-1:0] in_req_type,
  output logic                      out_valid,
  input  logic                      out_ready,
  input  dlt_pkg::dlt_sts_t         sts_i,
  output dlt_pkg::dlt_cmd_t         cmd_o
);
  import dlt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_WALK = 4'b0010,
    S_TAIL = 4'b0100,
    S_RESP = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    in_ready  = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_o.load = 1'b1;
          case (in_req_type)
            REQ_ADD: begin
              if (sts_i.full) begin
                state_nxt = S_RESP;
              end else if (sts_i.empty) begin
                state_nxt = S_TAIL;
              end else begin
                state_nxt = S_WALK;
              end
            end
            REQ_REMOVE, REQ_TICK: begin
              state_nxt = sts_i.empty ? S_RESP : S_WALK;
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end
      S_WALK: begin
        cmd_o.walk = 1'b1;
        if (sts_i.walk_done) begin
          state_nxt = sts_i.is_add ? S_TAIL : S_RESP;
        end
      end
      S_TAIL: begin
        cmd_o.tail = 1'b1;
        state_nxt  = S_RESP;
      end
      S_RESP: begin
        // hold until the output register frees up
        if (!out_valid_r || out_ready) begin
          cmd_o.resp_load = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd_o.resp_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: hdl/delta_list_timer.sv
// Channel  Dir  Beat payload
// in_ch    in   req_type, pkt_num, duration
// out_ch   out  status, expired_packet
//
// One request at a time. An add, remove or tick on a non-empty list walks the
// live entries through the single read port of the entry RAM, one per cycle;
// an add then appends one entry after the last live one, in the tail state.
// Removes and ticks on an empty list, full adds and unused codes skip the walk.
// Synchronous reset clears the entry count, walk flags and control state; RAM contents are don't-care.
// A result waits in the output register while the next beat is accepted;
// a second result then waits until the first one is taken.
module delta_list_timer #(
  parameter int MAX_TIMERS = dlt_pkg::DEFAULT_MAX_TIMERS
) (
  input logic       clk,
  input logic       rst_n,
  dlt_in_if.sink    in_ch,
  dlt_out_if.source out_ch
);
  import dlt_pkg::*;

  dlt_cmd_t cmd;
  dlt_sts_t sts;

  dlt_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_req_type (in_ch.req_type),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dlt_datapath #(
    .MAX_TIMERS (MAX_TIMERS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .in_req_type        (in_ch.req_type),
    .in_pkt_num         (in_ch.pkt_num),
    .in_duration        (in_ch.duration),
    .out_status         (out_ch.status),
    .out_expired_packet (out_ch.expired_packet)
  );

endmodule

FILE: sim/delta_list_timer_tb.sv
module delta_list_timer_tb;
  import dlt_pkg::*;

  localparam int DEPTH = DEFAULT_MAX_TIMERS;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int STUCK_LIMIT = 4000;
  localparam int DRAIN_CYCLES = DEPTH + 24;
  localparam int BACKPRESSURE_CYCLES = 300;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   expired_packet;
  } timer_result_t;

  logic clk;
  logic rst_n;

  dlt_in_if  in_ch ();
  dlt_out_if out_ch ();

  delta_list_timer #(.MAX_TIMERS(DEPTH)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // shadow copy of the delta list
  logic [DATA_W-1:0] tmr_delta [DEPTH];
  logic [DATA_W-1:0] tmr_pkt   [DEPTH];
  int                tmr_count;

  timer_result_t due_results[$];
  int err_count;
  int tx_idle_pct;
  int rx_idle_pct;
  int hold_left;
  int stuck_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void drop_timer(input int pos);
    int k;
    for (k = pos; k + 1 < tmr_count; k++) begin
      tmr_delta[k] = tmr_delta[k + 1];
      tmr_pkt[k]   = tmr_pkt[k + 1];
    end
    tmr_count--;
  endfunction

  function automatic timer_result_t timer_list_apply(input logic [REQ_W-1:0] req,
                                                     input logic [DATA_W-1:0] pkt,
                                                     input logic [DATA_W-1:0] dur);
    timer_result_t res;
    int pos;
    int k;
    logic [DATA_W-1:0] left;
    res.status = ST_DONE;
    res.expired_packet = '0;
    case (req)
      REQ_ADD: begin
        if (tmr_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          pos = 0;
          left = dur;
          // pass every entry whose delta fits in what remains
          while (pos < tmr_count && tmr_delta[pos] <= left) begin
            left = left - tmr_delta[pos];
            pos++;
          end
          if (pos < tmr_count) tmr_delta[pos] = tmr_delta[pos] - left;
          for (k = tmr_count; k > pos; k--) begin
            tmr_delta[k] = tmr_delta[k - 1];
            tmr_pkt[k]   = tmr_pkt[k - 1];
          end
          tmr_delta[pos] = left;
          tmr_pkt[pos]   = pkt;
          tmr_count++;
        end
      end
      REQ_REMOVE: begin
        res.status = ST_NOTFOUND;
        for (pos = 0; pos < tmr_count; pos++) begin
          if (tmr_pkt[pos] == pkt) break;
        end
        if (pos < tmr_count) begin
          res.status = ST_DONE;
          if (pos + 1 < tmr_count) tmr_delta[pos + 1] = tmr_delta[pos + 1] + tmr_delta[pos];
          drop_timer(pos);
        end
      end
      REQ_TICK: begin
        if (tmr_count > 0) begin
          if (tmr_delta[0] != '0) tmr_delta[0] = tmr_delta[0] - 1;
          // a zero head expires whether it was zero or just reached zero
          if (tmr_delta[0] == '0) begin
            res.status = ST_EXPIRED;
            res.expired_packet = tmr_pkt[0];
            drop_timer(0);
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    $display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
    err_count++;
  endtask

  task automatic send_req(input logic [REQ_W-1:0] req, input logic [DATA_W-1:0] pkt,
                          input logic [DATA_W-1:0] dur);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= req;
    in_ch.pkt_num  <= pkt;
    in_ch.duration <= dur;
    do @(posedge clk); while (!in_ch.ready);
    due_results.push_back(timer_list_apply(req, pkt, dur));
  endtask

  // receiver: random stalls, or a counted hold-off when one is requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    timer_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (due_results.size() == 0) begin
        report_mismatch("unexpected beat", {30'd0, out_ch.status}, '0);
      end else begin
        want = due_results.pop_front();
        if (out_ch.status !== want.status)
          report_mismatch("status", {30'd0, out_ch.status}, {30'd0, want.status});
        if (out_ch.expired_packet !== want.expired_packet)
          report_mismatch("expired_packet", out_ch.expired_packet, want.expired_packet);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles = stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("delta_list_timer_tb: done, errors");
        $finish;
      end
    end
  end

  task automatic test_directed();
    logic [DATA_W-1:0] pkt;
    logic [DATA_W-1:0] dur;
    int hit;
    int i;
    send_req(REQ_TICK, 32'h0, 32'h0);              // tick on empty list
    send_req(REQ_REMOVE, 32'h1234_5678, 32'h0);    // remove on empty list
    send_req(REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(REQ_ADD, 32'h0, 32'h0);
    send_req(REQ_TICK, 32'h0, 32'h0);              // zero head expires at once
    send_req(REQ_ADD, 32'hA5A5_5A5A, 32'd2);
    send_req(REQ_TICK, 32'h0, 32'h0);
    send_req(REQ_TICK, 32'h0, 32'h0);              // decrements to zero, expires
    // fill the store, with equal and zero delays on the way, then overflow it
    for (i = 0; i <= DEPTH; i++) begin
      case (i)
        0: dur = 32'hFFFF_FFFF;
        1, 2: dur = 32'd7;
        3: dur = 32'd3;
        4: dur = 32'd0;
        default: dur = $urandom_range(1, 40);
      endcase
      pkt = (i == 0) ? 32'hFFFF_FFFF : $urandom;
      send_req(REQ_ADD, pkt, dur);
    end
    send_req(REQ_REMOVE, tmr_pkt[DEPTH / 2], $urandom);
    send_req(REQ_REMOVE, tmr_pkt[tmr_count - 1], $urandom);
    do begin
      pkt = $urandom;
      hit = 0;
      for (i = 0; i < tmr_count; i++) if (tmr_pkt[i] == pkt) hit = 1;
    end while (hit != 0);
    send_req(REQ_REMOVE, pkt, 32'h0);
  endtask

  task automatic test_random(input int n_items, input int tx_pct, input int rx_pct);
    int i;
    int pick;
    logic [DATA_W-1:0] pkt;
    logic [DATA_W-1:0] dur;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      // small packet pool makes duplicates, so first-match removal is hit
      pkt = ($urandom_range(99) < 40) ? 32'($urandom_range(0, 7)) : 32'($urandom);
      pick = (tmr_count >= DEPTH - 2 && pick < 35) ? pick + 20 : pick;
      if (pick < 35) begin
        pick = $urandom_range(99);
        if (pick < 70) dur = $urandom_range(0, 24);
        else if (pick < 85) dur = $urandom_range(0, 3);
        else if (pick < 95) dur = $urandom;
        else dur = ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'h0;
        send_req(REQ_ADD, pkt, dur);
      end else if (pick < 55) begin
        if (tmr_count > 0 && $urandom_range(99) < 75)
          pkt = tmr_pkt[$urandom_range(tmr_count - 1)];
        send_req(REQ_REMOVE, pkt, $urandom);
      end else if (pick < 97) begin
        send_req(REQ_TICK, pkt, $urandom);
      end else begin
        send_req(REQ_UNUSED, pkt, $urandom);
      end
    end
  endtask

  task automatic test_backpressure();
    int i;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_left = BACKPRESSURE_CYCLES;
    // keep offering beats while the receiver holds off
    for (i = 0; i < 40; i++) begin
      if (i % 3 == 2) send_req(REQ_TICK, $urandom, $urandom);
      else send_req(REQ_ADD, $urandom, $urandom_range(0, 60));
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.req_type = REQ_TICK;
    in_ch.pkt_num  = '0;
    in_ch.duration = '0;
    out_ch.ready   = 1'b0;
    tmr_count      = 0;
    err_count      = 0;
    tx_idle_pct    = 26;
    rx_idle_pct    = 60;
    hold_left      = 0;
    stuck_cycles   = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random(480, 26, 60);
    test_backpressure();
    test_random(480, 60, 26);
    test_random(480, 0, 0);

    in_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("delta_list_timer_tb: done, clean");
    end else begin
      $display("delta_list_timer_tb: done, errors");
    end
    $finish;
  end

endmodule
